/* rtl/core/bsm_pkg.sv */
package bsm_pkg;

   // item and register field widths
   localparam int FUNC_W  = 2;
   localparam int ADDR_W  = 16;
   localparam int DATA_W  = 8;
   localparam int MAP_W   = 22;
   localparam int CSR_IDX_W = 2;
   localparam int BANK_W  = 8;

   // operations carried by an item
   localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_PRG   = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_CHR   = 2'd3;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PRG_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHR_SIZE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIRROR   = 2'd2;

   localparam logic [BANK_W-1:0] PRG_SIZE_RST = 8'd2;
   localparam logic [BANK_W-1:0] CHR_SIZE_RST = 8'd1;
   localparam logic              MIRROR_RST   = 1'b0;

   // register pairs picked by address bits 14:13
   localparam logic [1:0] PAIR_BANK      = 2'd0;
   localparam logic [1:0] PAIR_MIRROR    = 2'd1;
   localparam logic [1:0] PAIR_IRQ_LATCH = 2'd2;
   localparam logic [1:0] PAIR_IRQ_EN    = 2'd3;

   // 8 KiB program banks, 1 KiB pattern banks
   localparam int PRG_OFS_W = 13;
   localparam int CHR_OFS_W = 10;
   localparam int PRG_IDX_W = 9;
   localparam int CHR_IDX_W = 11;
   localparam int CNT_W     = 11;
   localparam int PRG_SLOTS = 4;
   localparam int CHR_SLOTS = 8;
   localparam int BANK_REGS = 8;

   localparam logic [BANK_W-1:0] BANK_SECOND_LAST = 8'hFE;
   localparam logic [BANK_W-1:0] BANK_LAST        = 8'hFF;
   localparam logic [BANK_W-1:0] BANK_ODD         = 8'h01;
   localparam logic [BANK_W-1:0] BANK_EVEN_MASK   = 8'hFE;

   typedef struct packed {
      logic              start;
      logic [BANK_W-1:0] bank;
      logic [CNT_W-1:0]  count;
   } mod_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [CNT_W-1:0] rem;
   } mod_rsp_type;

endpackage

/* rtl/core/bsm_chan_if.sv */
interface bsm_req_if import bsm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [ADDR_W-1:0] addr;
   logic [DATA_W-1:0] data_value;

   modport source (output valid, func, addr, data_value, input ready);
   modport sink (input valid, func, addr, data_value, output ready);
endinterface

interface bsm_rsp_if import bsm_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [MAP_W-1:0] mapped_addr;
   logic             mirror_mode;
   logic             irq;

   modport source (output valid, mapped_addr, mirror_mode, irq, input ready);
   modport sink (input valid, mapped_addr, mirror_mode, irq, output ready);
endinterface

interface bsm_csr_if import bsm_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] idx;
   logic [DATA_W-1:0]    data;

   modport source (output valid, idx, data, input ready);
   modport sink (input valid, idx, data, output ready);
endinterface

/* rtl/core/bsm_mod_unit.sv */
module bsm_mod_unit import bsm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mod_req_type mod_req,
   output mod_rsp_type mod_rsp
);

   localparam int STEP_W = $clog2(BANK_W + 1);
   localparam logic [STEP_W-1:0] STEP_FIX = STEP_W'(BANK_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [BANK_W-1:0] mag_ff, mag_in;
   logic              neg_ff, neg_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic              fix;
   logic [CNT_W:0]    sub_a, sub_b;
   logic [CNT_W+1:0]  diff;

   // restoring remainder of the bank magnitude, one bit a cycle, then sign wrap
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      count_in = count_ff;
      rem_in   = rem_ff;
      fix      = (step_ff == STEP_FIX);
      sub_a    = fix ? {1'b0, count_ff} : {rem_ff, mag_ff[BANK_W-1]};
      sub_b    = fix ? {1'b0, rem_ff} : {1'b0, count_ff};
      diff     = {1'b0, sub_a} - {1'b0, sub_b};
      if (mod_req.start) begin
         busy_in  = 1'b1;
         step_in  = '0;
         neg_in   = mod_req.bank[BANK_W-1];
         mag_in   = mod_req.bank[BANK_W-1] ? (~mod_req.bank + 1'b1) : mod_req.bank;
         count_in = mod_req.count;
         rem_in   = '0;
      end else if (busy_ff) begin
         if (fix) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            // negative bank with nonzero remainder wraps toward the end
            if (count_ff == '0) begin
               rem_in = '0;
            end else if (neg_ff && (rem_ff != '0)) begin
               rem_in = diff[CNT_W-1:0];
            end
         end else begin
            step_in = step_ff + 1'b1;
            mag_in  = {mag_ff[BANK_W-2:0], 1'b0};
            rem_in  = diff[CNT_W+1] ? sub_a[CNT_W-1:0] : diff[CNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      count_ff <= count_in;
      rem_ff   <= rem_in;
   end

   assign mod_rsp.busy = busy_ff;
   assign mod_rsp.done = done_ff;
   assign mod_rsp.rem  = rem_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("remainder done without a running division");

   // a start seen on the reset release edge is swallowed by the reset
   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      !reset && mod_req.start |=> busy_ff && (step_ff == '0))
      else $error("division did not start");

   a_rem_in_range: assert property (@(posedge clock) disable iff (reset)
      done_ff && (count_ff != '0) |-> rem_ff < count_ff)
      else $error("remainder not below bank count");

endmodule

/* rtl/core/bank_switch_mapper_with_scanline_irq_top.sv */
// channel   port       dir  payload
// request   req_chan   in   func, addr, data_value
// response  rsp_chan   out  mapped_addr, mirror_mode, irq
// config    csr_chan   in   idx, data
//
// translates, ticks and most writes are answered in the cycle after they are taken; the response is registered.
// a write to the bank select or a bank register recomputes all 12 bank offsets
// through one iterative modulo unit, one bank after another, with ready low meanwhile.
// after reset and after each config write to a known register a load of the 4 program
// banks runs with ready low; config is taken only while idle.
// a stalled response holds the request side: a new item waits until it is taken.
module bank_switch_mapper_with_scanline_irq_top import bsm_pkg::*; (
   input logic      clock,
   input logic      reset,
   bsm_req_if.sink  req_chan,
   bsm_rsp_if.source rsp_chan,
   bsm_csr_if.sink  csr_chan
);

   localparam logic [1:0] SEQ_IDLE  = 2'd0;
   localparam logic [1:0] SEQ_ISSUE = 2'd1;
   localparam logic [1:0] SEQ_WAIT  = 2'd2;

   localparam int JOB_W = 4;
   localparam logic [JOB_W-1:0] JOB_PRG_LAST = JOB_W'(PRG_SLOTS - 1);
   localparam logic [JOB_W-1:0] JOB_ALL_LAST = JOB_W'(PRG_SLOTS + CHR_SLOTS - 1);

   logic [1:0]       seq_state_ff, seq_state_in;
   logic             load_ff, load_in;
   logic [JOB_W-1:0] job_ff, job_in;

   logic [BANK_W-1:0] prg_size_ff, prg_size_in;
   logic [BANK_W-1:0] chr_size_ff, chr_size_in;
   logic              mirror_rst_ff, mirror_rst_in;

   logic [2:0]        bank_select_ff, bank_select_in;
   logic              prg_mode_ff, prg_mode_in;
   logic              chr_mode_ff, chr_mode_in;
   logic [BANK_W-1:0] bank_regs_ff [BANK_REGS];
   logic [BANK_W-1:0] bank_regs_in [BANK_REGS];
   logic              mirror_bit_ff, mirror_bit_in;
   logic [BANK_W-1:0] irq_reload_ff, irq_reload_in;
   logic [BANK_W-1:0] irq_counter_ff, irq_counter_in;
   logic              irq_enable_ff, irq_enable_in;
   logic [PRG_IDX_W-1:0] prg_idx_ff [PRG_SLOTS];
   logic [PRG_IDX_W-1:0] prg_idx_in [PRG_SLOTS];
   logic [CHR_IDX_W-1:0] chr_idx_ff [CHR_SLOTS];
   logic [CHR_IDX_W-1:0] chr_idx_in [CHR_SLOTS];

   logic             rsp_valid_ff, rsp_valid_in;
   logic [MAP_W-1:0] rsp_map_ff, rsp_map_in;
   logic             rsp_mirror_ff, rsp_mirror_in;
   logic             rsp_irq_ff, rsp_irq_in;

   logic        req_fire, csr_fire, idle;
   logic        wr_odd;
   logic [2:0]  chr_dest;
   logic [BANK_W-1:0] job_bank;
   mod_req_type mod_req;
   mod_rsp_type mod_rsp;

   bsm_mod_unit u_mod (
      .clock   (clock),
      .reset   (reset),
      .mod_req (mod_req),
      .mod_rsp (mod_rsp)
   );

   assign idle     = (seq_state_ff == SEQ_IDLE);
   assign csr_chan.ready = idle;
   assign req_chan.ready = idle && !csr_chan.valid && (!rsp_valid_ff || rsp_chan.ready);
   assign req_fire = req_chan.valid && req_chan.ready;
   assign csr_fire = csr_chan.valid && csr_chan.ready;
   assign wr_odd   = req_chan.addr[0];

   // bank number fed to the modulo unit for the current job
   always_comb begin
      job_bank = '0;
      if (load_ff) begin
         case (job_ff)
            4'd0:    job_bank = '0;
            4'd1:    job_bank = BANK_ODD;
            4'd2:    job_bank = BANK_SECOND_LAST;
            default: job_bank = BANK_LAST;
         endcase
      end else begin
         case (job_ff)
            4'd0:    job_bank = prg_mode_ff ? BANK_SECOND_LAST : bank_regs_ff[6];
            4'd1:    job_bank = bank_regs_ff[7];
            4'd2:    job_bank = prg_mode_ff ? bank_regs_ff[6] : BANK_SECOND_LAST;
            4'd3:    job_bank = BANK_LAST;
            4'd4:    job_bank = bank_regs_ff[0] & BANK_EVEN_MASK;
            4'd5:    job_bank = bank_regs_ff[0] | BANK_ODD;
            4'd6:    job_bank = bank_regs_ff[1] & BANK_EVEN_MASK;
            4'd7:    job_bank = bank_regs_ff[1] | BANK_ODD;
            4'd8:    job_bank = bank_regs_ff[2];
            4'd9:    job_bank = bank_regs_ff[3];
            4'd10:   job_bank = bank_regs_ff[4];
            4'd11:   job_bank = bank_regs_ff[5];
            default: job_bank = BANK_LAST;
         endcase
      end
      mod_req.start = (seq_state_ff == SEQ_ISSUE);
      mod_req.bank  = job_bank;
      if (job_ff <= JOB_PRG_LAST) begin
         mod_req.count = {2'b00, prg_size_ff, 1'b0};
      end else begin
         mod_req.count = {chr_size_ff, 3'b000};
      end
      // chr mode swaps the 2 KiB and 1 KiB halves
      chr_dest = (job_ff[2:0] ^ 3'b100) + {chr_mode_ff, 2'b00};
   end

   always_comb begin
      seq_state_in   = seq_state_ff;
      load_in        = load_ff;
      job_in         = job_ff;
      prg_size_in    = prg_size_ff;
      chr_size_in    = chr_size_ff;
      mirror_rst_in  = mirror_rst_ff;
      bank_select_in = bank_select_ff;
      prg_mode_in    = prg_mode_ff;
      chr_mode_in    = chr_mode_ff;
      bank_regs_in   = bank_regs_ff;
      mirror_bit_in  = mirror_bit_ff;
      irq_reload_in  = irq_reload_ff;
      irq_counter_in = irq_counter_ff;
      irq_enable_in  = irq_enable_ff;
      prg_idx_in     = prg_idx_ff;
      chr_idx_in     = chr_idx_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_map_in     = rsp_map_ff;
      rsp_mirror_in  = rsp_mirror_ff;
      rsp_irq_in     = rsp_irq_ff;

      if (csr_fire) begin
         case (csr_chan.idx)
            CSR_PRG_SIZE: prg_size_in   = csr_chan.data;
            CSR_CHR_SIZE: chr_size_in   = csr_chan.data;
            CSR_MIRROR:   mirror_rst_in = csr_chan.data[0];
            default: ;
         endcase
         // any known register reloads the cartridge state
         if ((csr_chan.idx == CSR_PRG_SIZE) || (csr_chan.idx == CSR_CHR_SIZE) ||
             (csr_chan.idx == CSR_MIRROR)) begin
            bank_select_in = '0;
            prg_mode_in    = 1'b0;
            chr_mode_in    = 1'b0;
            mirror_bit_in  = mirror_rst_in;
            irq_reload_in  = '0;
            irq_counter_in = '0;
            irq_enable_in  = 1'b0;
            for (int i = 0; i < BANK_REGS; i++) begin
               bank_regs_in[i] = '0;
            end
            for (int i = 0; i < CHR_SLOTS; i++) begin
               chr_idx_in[i] = '0;
            end
            seq_state_in = SEQ_ISSUE;
            load_in      = 1'b1;
            job_in       = '0;
         end
      end

      if (req_fire) begin
         rsp_irq_in = 1'b0;
         rsp_map_in = '0;
         case (req_chan.func)
            FUNC_WRITE: begin
               if (req_chan.addr[ADDR_W-1]) begin
                  case (req_chan.addr[14:13])
                     PAIR_BANK: begin
                        if (!wr_odd) begin
                           prg_mode_in    = req_chan.data_value[6];
                           chr_mode_in    = req_chan.data_value[7];
                           bank_select_in = req_chan.data_value[2:0];
                        end else begin
                           bank_regs_in[bank_select_ff] = req_chan.data_value;
                        end
                        seq_state_in = SEQ_ISSUE;
                        load_in      = 1'b0;
                        job_in       = '0;
                     end
                     PAIR_MIRROR: begin
                        if (!wr_odd) begin
                           mirror_bit_in = req_chan.data_value[0];
                        end
                     end
                     PAIR_IRQ_LATCH: begin
                        if (!wr_odd) begin
                           irq_reload_in = req_chan.data_value;
                        end else begin
                           irq_counter_in = irq_reload_ff;
                        end
                     end
                     default: irq_enable_in = wr_odd;
                  endcase
               end
            end
            FUNC_TICK: begin
               if (irq_counter_ff == '0) begin
                  irq_counter_in = irq_reload_ff;
               end else begin
                  irq_counter_in = irq_counter_ff - 1'b1;
                  rsp_irq_in     = (irq_counter_ff == 8'd1) && irq_enable_ff;
               end
            end
            FUNC_PRG: begin
               rsp_map_in = {prg_idx_ff[req_chan.addr[14:13]], req_chan.addr[PRG_OFS_W-1:0]};
            end
            default: begin
               rsp_map_in = {1'b0, chr_idx_ff[req_chan.addr[12:10]],
                             req_chan.addr[CHR_OFS_W-1:0]};
            end
         endcase
         rsp_valid_in  = 1'b1;
         rsp_mirror_in = mirror_bit_in;
      end

      case (seq_state_ff)
         SEQ_IDLE: ;
         SEQ_ISSUE: seq_state_in = SEQ_WAIT;
         SEQ_WAIT: begin
            if (mod_rsp.done) begin
               if (job_ff <= JOB_PRG_LAST) begin
                  prg_idx_in[job_ff[1:0]] = mod_rsp.rem[PRG_IDX_W-1:0];
               end else begin
                  chr_idx_in[chr_dest] = mod_rsp.rem;
               end
               if (job_ff == (load_ff ? JOB_PRG_LAST : JOB_ALL_LAST)) begin
                  seq_state_in = SEQ_IDLE;
               end else begin
                  seq_state_in = SEQ_ISSUE;
                  job_in       = job_ff + 1'b1;
               end
            end
         end
         default: seq_state_in = SEQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_state_ff   <= SEQ_ISSUE;
         load_ff        <= 1'b1;
         job_ff         <= '0;
         prg_size_ff    <= PRG_SIZE_RST;
         chr_size_ff    <= CHR_SIZE_RST;
         mirror_rst_ff  <= MIRROR_RST;
         bank_select_ff <= '0;
         prg_mode_ff    <= 1'b0;
         chr_mode_ff    <= 1'b0;
         mirror_bit_ff  <= MIRROR_RST;
         irq_reload_ff  <= '0;
         irq_counter_ff <= '0;
         irq_enable_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < BANK_REGS; i++) begin
            bank_regs_ff[i] <= '0;
         end
         for (int i = 0; i < CHR_SLOTS; i++) begin
            chr_idx_ff[i] <= '0;
         end
      end else begin
         seq_state_ff   <= seq_state_in;
         load_ff        <= load_in;
         job_ff         <= job_in;
         prg_size_ff    <= prg_size_in;
         chr_size_ff    <= chr_size_in;
         mirror_rst_ff  <= mirror_rst_in;
         bank_select_ff <= bank_select_in;
         prg_mode_ff    <= prg_mode_in;
         chr_mode_ff    <= chr_mode_in;
         mirror_bit_ff  <= mirror_bit_in;
         irq_reload_ff  <= irq_reload_in;
         irq_counter_ff <= irq_counter_in;
         irq_enable_ff  <= irq_enable_in;
         rsp_valid_ff   <= rsp_valid_in;
         bank_regs_ff   <= bank_regs_in;
         chr_idx_ff     <= chr_idx_in;
      end
      prg_idx_ff    <= prg_idx_in;
      rsp_map_ff    <= rsp_map_in;
      rsp_mirror_ff <= rsp_mirror_in;
      rsp_irq_ff    <= rsp_irq_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.mapped_addr = rsp_map_ff;
   assign rsp_chan.mirror_mode = rsp_mirror_ff;
   assign rsp_chan.irq         = rsp_irq_ff;

   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      mod_req.start |-> !mod_rsp.busy)
      else $error("modulo unit started while busy");

   a_cfg_reloads: assert property (@(posedge clock) disable iff (reset)
      csr_fire && (csr_chan.idx != CSR_MIRROR + 2'd1) |=>
         (seq_state_ff == SEQ_ISSUE) && load_ff && (job_ff == '0))
      else $error("config write did not start a bank load");

   a_irq_no_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_irq_ff |-> rsp_map_ff == '0)
      else $error("irq item carries a mapped address");

endmodule
